[design/tc3_pkg.sv]
package tc3_pkg;

    localparam int FRAC_BITS = 20;
    localparam int COEF_FRAC = 20;
    localparam int PWM_PERIOD_COUNTS = 23040;

    localparam int SAMPLE_W = 12;
    localparam int COEF_W = 24;
    localparam int ERR_W = 24;
    localparam int ERR_MAG_W = 23;
    localparam int HIST_E_W = 26;
    localparam int HIST_Y_W = 22;
    localparam int TMP_W = 22;
    localparam int CMP_W = 16;
    localparam int HALF_W = 15;
    localparam int CLAMP_W = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 24;

    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W = 52;
    localparam int YR_W = ACC_W - COEF_FRAC;

    localparam int ERR_DIVISOR = 1000;
    localparam int ERR_ROUND = ERR_DIVISOR / 2;
    localparam int ERR_QH = (1 << FRAC_BITS) / ERR_DIVISOR;
    localparam int ERR_RH = (1 << FRAC_BITS) % ERR_DIVISOR;
    localparam int DIV1000_SHIFT = 32;
    localparam longint DIV1000_K =
        ((longint'(1) << DIV1000_SHIFT) + ERR_DIVISOR - 1) / ERR_DIVISOR;
    localparam int DIV3_SHIFT = 20;
    localparam int DIV3_K = ((1 << DIV3_SHIFT) + 2) / 3;

    localparam longint VOSC_FX = longint'(3) << FRAC_BITS;
    localparam longint HIGH_FX = (276 * (longint'(1) << FRAC_BITS) + 50) / 100;
    localparam longint LOW_FX = (6 * (longint'(1) << FRAC_BITS) + 50) / 100;
    localparam int MIN_COMPARE = 100;

    localparam int X0_RESET = -435178;
    localparam int X1_RESET = 392648;
    localparam int X2_RESET = 435074;
    localparam int X3_RESET = -392751;
    localparam int Y1_RESET = 1167080;
    localparam int Y2_RESET = -41497;
    localparam int Y3_RESET = -77007;

    typedef logic [CFG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_TARGET = 4'd0;
    localparam reg_idx_t REG_X0 = 4'd1;
    localparam reg_idx_t REG_X1 = 4'd2;
    localparam reg_idx_t REG_X2 = 4'd3;
    localparam reg_idx_t REG_X3 = 4'd4;
    localparam reg_idx_t REG_Y1 = 4'd5;
    localparam reg_idx_t REG_Y2 = 4'd6;
    localparam reg_idx_t REG_Y3 = 4'd7;

    typedef logic [3:0] op_t;
    localparam op_t OP_ERR_LO = 4'd0;
    localparam op_t OP_ERR_DIV = 4'd1;
    localparam op_t OP_ERR_HI = 4'd2;
    localparam op_t OP_X0 = 4'd3;
    localparam op_t OP_X1 = 4'd4;
    localparam op_t OP_Y1 = 4'd5;
    localparam op_t OP_X2 = 4'd6;
    localparam op_t OP_Y2 = 4'd7;
    localparam op_t OP_X3 = 4'd8;
    localparam op_t OP_Y3 = 4'd9;
    localparam op_t OP_SCALE = 4'd10;
    localparam op_t OP_DIV3 = 4'd11;

    typedef logic [CLAMP_W-1:0] clamp_t;
    localparam clamp_t CLAMP_NONE = 2'd0;
    localparam clamp_t CLAMP_HIGH = 2'd1;
    localparam clamp_t CLAMP_LOW = 2'd2;

    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } tc3_mul_req_t;

endpackage

[design/tc3_mul.sv]
module tc3_mul (
    input  logic                                 clk,
    input  tc3_pkg::tc3_mul_req_t                req,
    output logic signed [tc3_pkg::MUL_P_W-1:0]   product
);
    import tc3_pkg::*;

    logic signed [MUL_P_W-1:0] product_reg;
    logic signed [MUL_P_W-1:0] product_next;

    always_comb
    begin
        product_next = req.a * req.b;
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

[design/type3_compensator_pwm.sv]
// Type-3 compensator that turns one ADC sample of the output voltage into a PWM
// compare value. Samples arrive on the s_axis stream, one 12-bit reading per word.
// Each word on the m_axis stream carries the compare value, half of it, and a
// code that tells whether the filter output was clamped high or low.
// Coefficients and the target level are written through the cfg channel, which
// is always ready; write it only while no sample is in flight.
// Every multiplication runs through one registered 27 x 24 bit multiplier under a
// sequencer: twelve multiplications, each with an issue state and a take state,
// a clamp state after the tenth, and a done state that passes the result on; a
// new sample is taken only once the previous one has reached the output register.
// s_axis_tready is high only while the sequencer is idle.
// When the receiver stalls, the finished result waits in the output register and
// the next sample is computed; its result is held back until the slot frees.
// Reset clears the filter history, returns the registers to their default
// coefficients and drops any pending result.
module type3_compensator_pwm (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // vout_sample[11:0], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // compare_main[15:0], compare_half[30:16],
                                        // clamp_state[32:31], zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [tc3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tc3_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tc3_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_TAKE = 3'd2;
    localparam logic [2:0] ST_CLAMP = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic signed [YR_W-1:0] Y_HIGH_LIMIT = YR_W'(VOSC_FX);
    localparam logic signed [YR_W-1:0] Y_LOW_LIMIT = YR_W'(LOW_FX);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(longint'(1) << (COEF_FRAC - 1));

    logic [2:0] state_reg, state_next;
    op_t op_reg, op_next;

    logic [SAMPLE_W-1:0] target_reg, target_next;
    logic signed [COEF_W-1:0] coef_x_reg [4];
    logic signed [COEF_W-1:0] coef_y_reg [3];

    logic signed [HIST_E_W-1:0] eh_reg [3];
    logic signed [HIST_E_W-1:0] eh_next [3];
    logic [HIST_Y_W-1:0] oh_reg [3];
    logic [HIST_Y_W-1:0] oh_next [3];

    logic neg_reg, neg_next;
    logic [SAMPLE_W-1:0] mag_reg, mag_next;
    logic [TMP_W-1:0] tmp_reg, tmp_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [HIST_Y_W-1:0] y_reg, y_next;
    clamp_t clamp_reg, clamp_next;

    logic m_valid_reg, m_valid_next;
    logic [CMP_W-1:0] m_main_reg, m_main_next;
    clamp_t m_clamp_reg, m_clamp_next;

    tc3_mul_req_t mul_req;
    logic signed [MUL_P_W-1:0] product;

    logic signed [SAMPLE_W:0] diff;
    logic [ERR_MAG_W-1:0] err_mag;
    logic signed [ACC_W-1:0] round_sum;
    logic signed [YR_W-1:0] y_raw;
    logic [CMP_W-1:0] cmp_raw;
    logic out_free;

    tc3_mul u_mul (
        .clk     (clk),
        .req     (mul_req),
        .product (product)
    );

    assign cfg_ready = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        mul_req.en = (state_reg == ST_ISSUE);
        mul_req.a = '0;
        mul_req.b = '0;
        unique case (op_reg)
            OP_ERR_LO:
            begin
                mul_req.a = MUL_A_W'(mag_reg);
                mul_req.b = MUL_B_W'(ERR_RH);
            end
            OP_ERR_DIV:
            begin
                mul_req.a = MUL_A_W'(tmp_reg);
                mul_req.b = MUL_B_W'(DIV1000_K);
            end
            OP_ERR_HI:
            begin
                mul_req.a = MUL_A_W'(mag_reg);
                mul_req.b = MUL_B_W'(ERR_QH);
            end
            OP_X0:
            begin
                mul_req.a = MUL_A_W'(err_reg);
                mul_req.b = coef_x_reg[0];
            end
            OP_X1:
            begin
                mul_req.a = MUL_A_W'(eh_reg[0]);
                mul_req.b = coef_x_reg[1];
            end
            OP_Y1:
            begin
                mul_req.a = MUL_A_W'(oh_reg[0]);
                mul_req.b = coef_y_reg[0];
            end
            OP_X2:
            begin
                mul_req.a = MUL_A_W'(eh_reg[1]);
                mul_req.b = coef_x_reg[2];
            end
            OP_Y2:
            begin
                mul_req.a = MUL_A_W'(oh_reg[1]);
                mul_req.b = coef_y_reg[1];
            end
            OP_X3:
            begin
                mul_req.a = MUL_A_W'(eh_reg[2]);
                mul_req.b = coef_x_reg[3];
            end
            OP_Y3:
            begin
                mul_req.a = MUL_A_W'(oh_reg[2]);
                mul_req.b = coef_y_reg[2];
            end
            OP_SCALE:
            begin
                mul_req.a = MUL_A_W'(y_reg);
                mul_req.b = MUL_B_W'(PWM_PERIOD_COUNTS);
            end
            OP_DIV3:
            begin
                mul_req.a = MUL_A_W'(tmp_reg);
                mul_req.b = MUL_B_W'(DIV3_K);
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    always_comb
    begin
        diff = $signed({1'b0, s_axis_tdata[SAMPLE_W-1:0]}) - $signed({1'b0, target_reg});
        err_mag = product[ERR_MAG_W-1:0] + ERR_MAG_W'(tmp_reg);
        round_sum = acc_reg + ROUND_HALF;
        y_raw = YR_W'(round_sum >>> COEF_FRAC);
        cmp_raw = tmp_reg[CMP_W-1:0];

        state_next = state_reg;
        op_next = op_reg;
        neg_next = neg_reg;
        mag_next = mag_reg;
        tmp_next = tmp_reg;
        err_next = err_reg;
        acc_next = acc_reg;
        y_next = y_reg;
        clamp_next = clamp_reg;
        eh_next = eh_reg;
        oh_next = oh_reg;
        m_main_next = m_main_reg;
        m_clamp_next = m_clamp_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    neg_next = diff[SAMPLE_W];
                    mag_next = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : SAMPLE_W'(diff);
                    op_next = OP_ERR_LO;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_TAKE;
            end
            ST_TAKE:
            begin
                op_next = op_reg + op_t'(1);
                state_next = ST_ISSUE;
                unique case (op_reg)
                    OP_ERR_LO:
                    begin
                        tmp_next = product[TMP_W-1:0] + TMP_W'(ERR_ROUND);
                    end
                    OP_ERR_DIV:
                    begin
                        tmp_next = TMP_W'(product[DIV1000_SHIFT +: SAMPLE_W]);
                    end
                    OP_ERR_HI:
                    begin
                        err_next = neg_reg ? -$signed({1'b0, err_mag}) : $signed({1'b0, err_mag});
                        acc_next = '0;
                    end
                    OP_X0, OP_X1, OP_Y1, OP_X2, OP_Y2, OP_X3:
                    begin
                        acc_next = acc_reg + ACC_W'(product);
                    end
                    OP_Y3:
                    begin
                        acc_next = acc_reg + ACC_W'(product);
                        state_next = ST_CLAMP;
                    end
                    OP_SCALE:
                    begin
                        tmp_next = product[FRAC_BITS +: TMP_W];
                    end
                    OP_DIV3:
                    begin
                        tmp_next = TMP_W'(product[DIV3_SHIFT +: CMP_W]);
                        op_next = OP_ERR_LO;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_CLAMP:
            begin
                priority if (y_raw >= Y_HIGH_LIMIT)
                begin
                    y_next = HIST_Y_W'(HIGH_FX);
                    clamp_next = CLAMP_HIGH;
                end
                else if (y_raw <= Y_LOW_LIMIT)
                begin
                    y_next = HIST_Y_W'(LOW_FX);
                    clamp_next = CLAMP_LOW;
                end
                else
                begin
                    y_next = y_raw[HIST_Y_W-1:0];
                    clamp_next = CLAMP_NONE;
                end
                eh_next[2] = eh_reg[1];
                eh_next[1] = eh_reg[0];
                eh_next[0] = HIST_E_W'(err_reg);
                oh_next[2] = oh_reg[1];
                oh_next[1] = oh_reg[0];
                oh_next[0] = y_next;
                op_next = OP_SCALE;
                state_next = ST_ISSUE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_main_next = (cmp_raw <= CMP_W'(MIN_COMPARE)) ? CMP_W'(MIN_COMPARE) : cmp_raw;
                    m_clamp_next = clamp_reg;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        target_next = target_reg;
        if (cfg_valid && cfg_index == REG_TARGET)
        begin
            target_next = cfg_data[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_ERR_LO;
            m_valid_reg <= 1'b0;
            target_reg <= '0;
            coef_x_reg[0] <= COEF_W'(X0_RESET);
            coef_x_reg[1] <= COEF_W'(X1_RESET);
            coef_x_reg[2] <= COEF_W'(X2_RESET);
            coef_x_reg[3] <= COEF_W'(X3_RESET);
            coef_y_reg[0] <= COEF_W'(Y1_RESET);
            coef_y_reg[1] <= COEF_W'(Y2_RESET);
            coef_y_reg[2] <= COEF_W'(Y3_RESET);
            for (int i = 0; i < 3; i++)
            begin
                eh_reg[i] <= '0;
                oh_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            m_valid_reg <= m_valid_next;
            target_reg <= target_next;
            eh_reg <= eh_next;
            oh_reg <= oh_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_TARGET: ;
                    REG_X0: coef_x_reg[0] <= $signed(cfg_data);
                    REG_X1: coef_x_reg[1] <= $signed(cfg_data);
                    REG_X2: coef_x_reg[2] <= $signed(cfg_data);
                    REG_X3: coef_x_reg[3] <= $signed(cfg_data);
                    REG_Y1: coef_y_reg[0] <= $signed(cfg_data);
                    REG_Y2: coef_y_reg[1] <= $signed(cfg_data);
                    REG_Y3: coef_y_reg[2] <= $signed(cfg_data);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        tmp_reg <= tmp_next;
        err_reg <= err_next;
        acc_reg <= acc_next;
        y_reg <= y_next;
        clamp_reg <= clamp_next;
        m_main_reg <= m_main_next;
        m_clamp_reg <= m_clamp_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = {7'b0, m_clamp_reg, m_main_reg[CMP_W-1:1], m_main_reg};

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Sample accepted while the sequencer was still busy.");

    a_compare_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:0] >= CMP_W'(MIN_COMPARE))
        else $error("Compare value below its floor.");

    a_half_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[30:16] == m_axis_tdata[15:1])
        else $error("Half compare value does not match the main value.");

    a_clamp_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[32:31] == CLAMP_NONE
            || m_axis_tdata[32:31] == CLAMP_HIGH || m_axis_tdata[32:31] == CLAMP_LOW))
        else $error("Clamp code out of range.");

    a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> op_reg <= OP_DIV3)
        else $error("Sequencer step counter out of range.");

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tc3_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 108;
    localparam int NEAR_SPREAD = 40;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

    typedef struct {
        logic [CMP_W-1:0]  compare_main;
        logic [HALF_W-1:0] compare_half;
        clamp_t            clamp_state;
    } pwm_word_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Filter model state and register copies.
    logic [SAMPLE_W-1:0]       model_target;
    logic signed [COEF_W-1:0]  coef_err [0:3];
    logic signed [COEF_W-1:0]  coef_out [1:3];
    logic signed [HIST_E_W-1:0] err_hist [1:3];
    logic [HIST_Y_W-1:0]       out_hist [1:3];

    logic [SAMPLE_W-1:0] pending_samples [$];
    pwm_word_t           expected_pwm [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  error_count = 0;
    int  stall_cycles = 0;
    bit  sample_taken = 1'b0;

    type3_compensator_pwm DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void clear_filter_model();
        model_target = '0;
        coef_err[0] = COEF_W'(X0_RESET);
        coef_err[1] = COEF_W'(X1_RESET);
        coef_err[2] = COEF_W'(X2_RESET);
        coef_err[3] = COEF_W'(X3_RESET);
        coef_out[1] = COEF_W'(Y1_RESET);
        coef_out[2] = COEF_W'(Y2_RESET);
        coef_out[3] = COEF_W'(Y3_RESET);
        for (int i = 1; i <= 3; i++)
        begin
            err_hist[i] = '0;
            out_hist[i] = '0;
        end
    endfunction

    function automatic void apply_register(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_TARGET: model_target = value[SAMPLE_W-1:0];
            REG_X0:     coef_err[0] = value;
            REG_X1:     coef_err[1] = value;
            REG_X2:     coef_err[2] = value;
            REG_X3:     coef_err[3] = value;
            REG_Y1:     coef_out[1] = value;
            REG_Y2:     coef_out[2] = value;
            REG_Y3:     coef_out[3] = value;
            default:    ;
        endcase
    endfunction

    function automatic pwm_word_t compensate_sample(input logic [SAMPLE_W-1:0] sample);
        longint    diff;
        longint    mag;
        longint    err;
        longint    acc;
        longint    y;
        longint    cmp;
        pwm_word_t res;
        diff = longint'(sample) - longint'(model_target);
        mag = (diff < 0) ? -diff : diff;
        err = ((mag << FRAC_BITS) + ERR_ROUND) / ERR_DIVISOR;
        if (diff < 0)
            err = -err;
        acc = longint'(coef_err[0]) * err;
        for (int i = 1; i <= 3; i++)
        begin
            acc += longint'(coef_err[i]) * longint'(err_hist[i]);
            acc += longint'(coef_out[i]) * longint'({1'b0, out_hist[i]});
        end
        y = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
        res.clamp_state = CLAMP_NONE;
        if (y >= VOSC_FX)
        begin
            y = HIGH_FX;
            res.clamp_state = CLAMP_HIGH;
        end
        else if (y <= LOW_FX)
        begin
            y = LOW_FX;
            res.clamp_state = CLAMP_LOW;
        end
        err_hist[3] = err_hist[2];
        err_hist[2] = err_hist[1];
        err_hist[1] = err[HIST_E_W-1:0];
        out_hist[3] = out_hist[2];
        out_hist[2] = out_hist[1];
        out_hist[1] = y[HIST_Y_W-1:0];
        cmp = (y * PWM_PERIOD_COUNTS) / (longint'(3) << FRAC_BITS);
        if (cmp <= MIN_COMPARE)
            cmp = MIN_COMPARE;
        res.compare_main = cmp[CMP_W-1:0];
        res.compare_half = cmp[CMP_W-1:1];
        return res;
    endfunction

    // Sample driver and output-side ready driver.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (!s_axis_tvalid || sample_taken)
            begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tdata <= {{(16 - SAMPLE_W){1'b0}}, pending_samples.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor and prediction.
    always @(posedge clk)
    begin
        pwm_word_t want;
        sample_taken = s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pwm.size() == 0)
                begin
                    $error("result word with no sample pending: %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_pwm.pop_front();
                    if (m_axis_tdata[15:0] !== want.compare_main)
                    begin
                        $error("compare_main: expected %0d, actual %0d",
                               want.compare_main, m_axis_tdata[15:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[30:16] !== want.compare_half)
                    begin
                        $error("compare_half: expected %0d, actual %0d",
                               want.compare_half, m_axis_tdata[30:16]);
                        error_count++;
                    end
                    if (m_axis_tdata[32:31] !== want.clamp_state)
                    begin
                        $error("clamp_state: expected %0d, actual %0d",
                               want.clamp_state, m_axis_tdata[32:31]);
                        error_count++;
                    end
                end
            end
            if (sample_taken)
                expected_pwm.push_back(compensate_sample(s_axis_tdata[SAMPLE_W-1:0]));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input logic [SAMPLE_W-1:0] target,
                                 input logic [CFG_DATA_W-1:0] coefs [7]);
        logic [CFG_DATA_W-1:0] target_word;
        target_word = CFG_DATA_W'($urandom());
        target_word[SAMPLE_W-1:0] = target;
        write_reg(REG_TARGET, target_word);
        write_reg(REG_X0, coefs[0]);
        write_reg(REG_X1, coefs[1]);
        write_reg(REG_X2, coefs[2]);
        write_reg(REG_X3, coefs[3]);
        write_reg(REG_Y1, coefs[4]);
        write_reg(REG_Y2, coefs[5]);
        write_reg(REG_Y3, coefs[6]);
        write_reg(reg_idx_t'($urandom_range(2 ** CFG_IDX_W - 1, REG_Y3 + 1)),
                  CFG_DATA_W'($urandom()));
    endtask

    task automatic wait_drained();
        while (pending_samples.size() > 0 || s_axis_tvalid || expected_pwm.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] next_sample();
        int v;
        if ($urandom_range(3) == 0)
            return SAMPLE_W'($urandom_range(SAMPLE_MAX));
        v = int'(model_target) + int'($urandom_range(2 * NEAR_SPREAD)) - NEAR_SPREAD;
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return SAMPLE_W'(v);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] extreme_coef();
        case ($urandom_range(2))
            0:       return {1'b1, {(CFG_DATA_W - 1){1'b0}}};
            1:       return {1'b0, {(CFG_DATA_W - 1){1'b1}}};
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    initial
    begin
        logic [CFG_DATA_W-1:0] reset_coefs [7];
        logic [CFG_DATA_W-1:0] coef_set [7];
        logic [SAMPLE_W-1:0]   target;
        reset_coefs = '{CFG_DATA_W'(X0_RESET), CFG_DATA_W'(X1_RESET), CFG_DATA_W'(X2_RESET),
                        CFG_DATA_W'(X3_RESET), CFG_DATA_W'(Y1_RESET), CFG_DATA_W'(Y2_RESET),
                        CFG_DATA_W'(Y3_RESET)};
        clear_filter_model();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 31;
        recv_idle_pct = 53;

        // Default registers straight out of reset.
        pending_samples = '{12'd0, 12'd4095, 12'd1, 12'd2048, 12'd4094};
        wait_drained();

        // Full-scale negative error against a full-scale target, aimed at the clamps.
        write_reg(REG_TARGET, {12'hFFF, 12'd4095});
        pending_samples = '{12'd0, 12'd0, 12'd4095, 12'd2000};
        wait_drained();

        // Small errors around mid scale.
        write_reg(REG_TARGET, CFG_DATA_W'(2048));
        pending_samples = '{12'd2048, 12'd2047, 12'd2049, 12'd2052, 12'd2044,
                            12'd2060, 12'd2036};
        wait_drained();

        foreach (coef_set[i])
            coef_set[i] = {1'b0, {(CFG_DATA_W - 1){1'b1}}};
        load_settings(12'd0, coef_set);
        pending_samples = '{12'd4095, 12'd0, 12'd100};
        wait_drained();

        foreach (coef_set[i])
            coef_set[i] = {1'b1, {(CFG_DATA_W - 1){1'b0}}};
        load_settings(12'd4095, coef_set);
        pending_samples = '{12'd0, 12'd4095, 12'd1};
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph < 2)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 53;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 53;
                recv_idle_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            target = SAMPLE_W'($urandom_range(SAMPLE_MAX));
            case (ph)
                0, 3, 5: coef_set = reset_coefs;
                1, 4:
                begin
                    foreach (coef_set[i])
                        coef_set[i] = extreme_coef();
                    if (ph == 4)
                        target = ($urandom_range(1) == 0) ? '0 : SAMPLE_W'(SAMPLE_MAX);
                end
                default:
                begin
                    foreach (coef_set[i])
                        coef_set[i] = CFG_DATA_W'($urandom_range(2097152) - 1048576);
                end
            endcase
            if (ph == 3)
                target = SAMPLE_W'(2048);
            load_settings(target, coef_set);
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_samples.push_back(next_sample());
            wait_drained();
        end

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
design/tc3_pkg.sv
design/tc3_mul.sv
design/type3_compensator_pwm.sv
test/tb_top.sv
